@@ hdl/lzw_byte_compressor_macros.svh @@
// ----------------------------------------------------------------------------
// lzw byte compressor assertion macros
// shared concurrent assertion forms for the compressor rtl
// ----------------------------------------------------------------------------
`ifndef LZW_BYTE_COMPRESSOR_MACROS_SVH
`define LZW_BYTE_COMPRESSOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LZWC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LZWC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/lzwc_pkg.sv @@
// ----------------------------------------------------------------------------
// lzwc_pkg
// constants, types and helper functions shared by the lzw compressor modules
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int DICT_SIZE   = 4096;
    localparam int FIRST_PHR   = 256;
    localparam int CODE_W      = $clog2(DICT_SIZE);
    localparam int NFC_W       = CODE_W + 1;
    localparam int KEY_W       = CODE_W + 8;
    localparam int TABLE_DEPTH = DICT_SIZE - FIRST_PHR;
    localparam int PHR_AW      = $clog2(TABLE_DEPTH);
    localparam int HASH_W      = CODE_W + 1;
    localparam int HASH_DEPTH  = 2 ** HASH_W;
    localparam int OUT_W       = 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH_CHK,
        ST_PHR_CMP,
        ST_INSERT,
        ST_FINAL
    } lzwc_state_t;

    typedef struct packed {
        logic              hash_rd;
        logic [HASH_W-1:0] hash_rd_addr;
        logic              hash_wr;
        logic [HASH_W-1:0] hash_wr_addr;
        logic [CODE_W-1:0] hash_wr_code;
        logic              phr_rd;
        logic [PHR_AW-1:0] phr_rd_addr;
        logic              phr_wr;
        logic [PHR_AW-1:0] phr_wr_addr;
        logic [KEY_W-1:0]  phr_wr_key;
        logic [HASH_W-1:0] phr_wr_slot;
    } lzwc_dict_req_t;

    typedef struct packed {
        logic              ready;
        logic [CODE_W-1:0] hash_code;
        logic [KEY_W-1:0]  phr_key;
        logic [HASH_W-1:0] phr_slot;
    } lzwc_dict_rsp_t;

    typedef struct packed {
        logic             last_code;
        logic [OUT_W-1:0] code;
    } lzwc_out_t;

    function automatic logic [HASH_W-1:0] lzwc_hash(input logic [CODE_W-1:0] prefix,
                                                    input logic [7:0] data_byte);
        logic [HASH_W-1:0] hp;
        logic [HASH_W-1:0] hb;
        hp = HASH_W'(prefix);
        hb = HASH_W'(data_byte) << (HASH_W - 8);
        return hp ^ hb;
    endfunction

    function automatic logic [OUT_W-1:0] lzwc_out_code(input logic [CODE_W-1:0] code);
        logic [CODE_W+OUT_W-1:0] ext;
        ext = (CODE_W + OUT_W)'(code);
        return ext[OUT_W-1:0];
    endfunction

endpackage

@@ hdl/lzwc_dict.sv @@
// ----------------------------------------------------------------------------
// lzwc_dict
// hash slot memory and phrase memory, with a clearing pass over the hash slots
// ----------------------------------------------------------------------------
module lzwc_dict (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  lzwc_pkg::lzwc_dict_req_t req,
    output lzwc_pkg::lzwc_dict_rsp_t rsp
);
    import lzwc_pkg::*;

    logic [CODE_W-1:0]        hash_mem [HASH_DEPTH];
    logic [HASH_W+KEY_W-1:0]  phr_mem  [TABLE_DEPTH];

    logic              clearing_reg;
    logic              clearing_next;
    logic [HASH_W-1:0] clr_addr_reg;
    logic [HASH_W-1:0] clr_addr_next;

    logic                    hwr_en;
    logic [HASH_W-1:0]       hwr_addr;
    logic [CODE_W-1:0]       hwr_code;
    logic [CODE_W-1:0]       hash_rd_reg;
    logic [HASH_W+KEY_W-1:0] phr_rd_reg;

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {HASH_W{1'b1}}) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // code zero is below the first phrase code, so it marks an empty slot
    always_comb begin
        if (clearing_reg) begin
            hwr_en   = 1'b1;
            hwr_addr = clr_addr_reg;
            hwr_code = '0;
        end else begin
            hwr_en   = req.hash_wr;
            hwr_addr = req.hash_wr_addr;
            hwr_code = req.hash_wr_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (hwr_en) begin
            hash_mem[hwr_addr] <= hwr_code;
        end
        if (req.hash_rd) begin
            hash_rd_reg <= hash_mem[req.hash_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.phr_wr) begin
            phr_mem[req.phr_wr_addr] <= {req.phr_wr_slot, req.phr_wr_key};
        end
        if (req.phr_rd) begin
            phr_rd_reg <= phr_mem[req.phr_rd_addr];
        end
    end

    assign rsp.ready     = !clearing_reg;
    assign rsp.hash_code = hash_rd_reg;
    assign rsp.phr_key   = phr_rd_reg[KEY_W-1:0];
    assign rsp.phr_slot  = phr_rd_reg[HASH_W+KEY_W-1:KEY_W];

endmodule

@@ hdl/lzwc_out_fifo.sv @@
// ----------------------------------------------------------------------------
// lzwc_out_fifo
// two-entry result queue between the compressor control and the output port
// ----------------------------------------------------------------------------
module lzwc_out_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lzwc_pkg::lzwc_out_t push_item,
    output logic                full,
    output logic                m_valid,
    input  logic                m_ready,
    output lzwc_pkg::lzwc_out_t m_item
);
    import lzwc_pkg::*;

    lzwc_out_t   item_mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;
    logic        do_push;

    assign pop     = m_valid && m_ready;
    assign do_push = push && !full;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({do_push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            item_mem[wr_ptr_reg] <= push_item;
        end
    end

    assign full    = (count_reg == 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_item  = item_mem[rd_ptr_reg];

endmodule

@@ hdl/lzwc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lzwc_ctrl
// prefix state, probe sequencer and insert logic of the lzw compressor
// ----------------------------------------------------------------------------
`include "lzw_byte_compressor_macros.svh"

module lzwc_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               in_byte,
    input  logic                     in_last,
    output lzwc_pkg::lzwc_dict_req_t dict_req,
    input  lzwc_pkg::lzwc_dict_rsp_t dict_rsp,
    output logic                     out_push,
    output lzwc_pkg::lzwc_out_t      out_item,
    input  logic                     fifo_full
);
    import lzwc_pkg::*;

    localparam logic [CODE_W-1:0] FIRST_CODE = CODE_W'(FIRST_PHR);
    localparam logic [NFC_W-1:0]  NFC_FIRST  = NFC_W'(FIRST_PHR);
    localparam logic [NFC_W-1:0]  NFC_DICT   = NFC_W'(DICT_SIZE);

    lzwc_state_t       state_reg;
    lzwc_state_t       state_next;
    logic [CODE_W-1:0] prefix_reg;
    logic [CODE_W-1:0] prefix_next;
    logic              held_reg;
    logic              held_next;
    logic [NFC_W-1:0]  nfc_reg;
    logic [NFC_W-1:0]  nfc_next;
    logic [7:0]        byte_reg;
    logic [7:0]        byte_next;
    logic              last_reg;
    logic              last_next;
    logic [HASH_W-1:0] slot_reg;
    logic [HASH_W-1:0] slot_next;
    logic [CODE_W-1:0] cand_reg;
    logic [CODE_W-1:0] cand_next;

    logic              accept;
    logic              cand_ok;
    logic              key_eq;
    logic              slot_eq;
    logic [KEY_W-1:0]  cur_key;
    logic [HASH_W-1:0] first_slot;
    logic [CODE_W-1:0] cand_off;
    logic [NFC_W-1:0]  nfc_off;
    logic              room;

    assign in_ready   = (state_reg == ST_IDLE) && dict_rsp.ready;
    assign accept     = in_valid && in_ready;
    assign cur_key    = {prefix_reg, byte_reg};
    assign first_slot = lzwc_hash(prefix_reg, in_byte);
    assign cand_ok    = (dict_rsp.hash_code >= FIRST_CODE) &&
                        (NFC_W'(dict_rsp.hash_code) < nfc_reg);
    assign key_eq     = (dict_rsp.phr_key == cur_key);
    // a slot is taken only while the phrase entry it names points back at it
    assign slot_eq    = (dict_rsp.phr_slot == slot_reg);
    assign cand_off   = dict_rsp.hash_code - FIRST_CODE;
    assign nfc_off    = nfc_reg - NFC_FIRST;
    assign room       = (nfc_reg < NFC_DICT);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (held_reg) begin
                        state_next = ST_HASH_CHK;
                    end else if (in_last) begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_HASH_CHK: begin
                state_next = cand_ok ? ST_PHR_CMP : ST_INSERT;
            end
            ST_PHR_CMP: begin
                if (!slot_eq) begin
                    state_next = ST_INSERT;
                end else if (key_eq) begin
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end else begin
                    state_next = ST_HASH_CHK;
                end
            end
            ST_INSERT: begin
                if (!fifo_full) begin
                    state_next = last_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL: begin
                if (!fifo_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // slot and phrase entries written by an insert are read no earlier than the next item
    always_comb begin
        prefix_next        = prefix_reg;
        held_next          = held_reg;
        nfc_next           = nfc_reg;
        byte_next          = byte_reg;
        last_next          = last_reg;
        slot_next          = slot_reg;
        cand_next          = cand_reg;
        dict_req           = '0;
        out_push           = 1'b0;
        out_item.code      = lzwc_out_code(prefix_reg);
        out_item.last_code = (state_reg == ST_FINAL);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    byte_next = in_byte;
                    last_next = in_last;
                    if (held_reg) begin
                        slot_next             = first_slot;
                        dict_req.hash_rd      = 1'b1;
                        dict_req.hash_rd_addr = first_slot;
                    end else begin
                        prefix_next = CODE_W'(in_byte);
                        held_next   = 1'b1;
                    end
                end
            end
            ST_HASH_CHK: begin
                cand_next            = dict_rsp.hash_code;
                dict_req.phr_rd      = cand_ok;
                dict_req.phr_rd_addr = cand_off[PHR_AW-1:0];
            end
            ST_PHR_CMP: begin
                if (slot_eq && key_eq) begin
                    prefix_next = cand_reg;
                end else if (slot_eq) begin
                    slot_next             = slot_reg + 1'b1;
                    dict_req.hash_rd      = 1'b1;
                    dict_req.hash_rd_addr = slot_reg + 1'b1;
                end
            end
            ST_INSERT: begin
                if (!fifo_full) begin
                    out_push    = 1'b1;
                    prefix_next = CODE_W'(byte_reg);
                    if (room) begin
                        dict_req.hash_wr      = 1'b1;
                        dict_req.hash_wr_addr = slot_reg;
                        dict_req.hash_wr_code = nfc_reg[CODE_W-1:0];
                        dict_req.phr_wr       = 1'b1;
                        dict_req.phr_wr_addr  = nfc_off[PHR_AW-1:0];
                        dict_req.phr_wr_key   = cur_key;
                        dict_req.phr_wr_slot  = slot_reg;
                        nfc_next              = nfc_reg + 1'b1;
                    end
                end
            end
            ST_FINAL: begin
                if (!fifo_full) begin
                    out_push    = 1'b1;
                    held_next   = 1'b0;
                    prefix_next = '0;
                    nfc_next    = NFC_FIRST;
                end
            end
            default: begin
                held_next = held_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            prefix_reg <= '0;
            held_reg   <= 1'b0;
            nfc_reg    <= NFC_FIRST;
        end else begin
            state_reg  <= state_next;
            prefix_reg <= prefix_next;
            held_reg   <= held_next;
            nfc_reg    <= nfc_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        slot_reg <= slot_next;
        cand_reg <= cand_next;
    end

    `LZWC_ASSERT_NOW(a_nfc_range, aclk, aresetn, 1'b1, (nfc_reg >= NFC_FIRST) && (nfc_reg <= NFC_DICT), "next free code out of range")
    `LZWC_ASSERT_NOW(a_accept_cleared, aclk, aresetn, accept, dict_rsp.ready, "item taken during clearing pass")
    `LZWC_ASSERT_NOW(a_cand_range, aclk, aresetn, state_reg == ST_PHR_CMP, (cand_reg >= FIRST_CODE) && (NFC_W'(cand_reg) < nfc_reg), "compare on a code outside the live table")
    `LZWC_ASSERT_NEXT(a_stream_restart, aclk, aresetn, out_push && out_item.last_code, (nfc_reg == NFC_FIRST) && !held_reg, "stream state not restarted after final code")

endmodule

@@ hdl/lzw_byte_compressor.sv @@
// ----------------------------------------------------------------------------
// lzw_byte_compressor
// lzw compressor, one byte per input transfer, one code per output transfer
// ----------------------------------------------------------------------------
// After reset the block sweeps its 8192-slot hash memory, one slot per cycle,
// and holds s_tready low until the sweep ends. The first byte of a stream is
// taken as the prefix without a probe. Every later byte is accepted and then
// reads hash slots in turn; a slot that holds a live code also needs a phrase
// read and a key compare. A match ends the byte there. A new pair ends on a
// free or stale slot and adds an insert step that sends the prefix code and,
// while the table has room, stores the pair. The code that closes a stream
// (m_tlast high) is sent from a final step of its own. Results queue in a
// two-entry buffer, so m_tready low only stalls the block once that buffer
// is full.
module lzw_byte_compressor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_code[11:0], zero[15:12]
    output logic        m_tlast
);
    import lzwc_pkg::*;

    lzwc_dict_req_t dict_req;
    lzwc_dict_rsp_t dict_rsp;
    lzwc_out_t      push_item;
    lzwc_out_t      head_item;
    logic           push;
    logic           fifo_full;

    lzwc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .dict_req  (dict_req),
        .dict_rsp  (dict_rsp),
        .out_push  (push),
        .out_item  (push_item),
        .fifo_full (fifo_full)
    );

    lzwc_dict u_dict (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dict_req),
        .rsp     (dict_rsp)
    );

    lzwc_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_item    (head_item)
    );

    assign m_tdata = {4'b0000, head_item.code};
    assign m_tlast = head_item.last_code;

endmodule
